[hdl/bdt_pkg.sv]
//------------------------------------------------------------------------------
// bdt_pkg
// Shared constants, types and helpers for the binomial 2:1 reduction block.
//------------------------------------------------------------------------------
`default_nettype none

package bdt_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SIZE_BITS   = 11;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int COLSUM_BITS = SAMPLE_BITS + 2;
    localparam int TOTAL_BITS  = SAMPLE_BITS + 5;
    localparam int WORD_BITS   = 2 * SAMPLE_BITS;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT    = FIFO_PTR + 1;
    localparam logic [SIZE_BITS-1:0] MIN_SIZE = SIZE_BITS'(3);

    typedef enum logic {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                row_odd;
        logic                row_is_one;
        logic                last_row;
        logic                last_col;
        logic                col_odd;
        logic                col_is_one;
    } pos_ctrl_t;

    typedef struct packed {
        logic                          s1_valid;
        logic                          s2_valid;
    } pipe_busy_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          end_of_row;
        logic                          end_of_frame;
    } out_beat_t;

    function automatic logic [SIZE_BITS-1:0] clamp_size(
        input logic [SIZE_BITS-1:0] v,
        input logic [SIZE_BITS-1:0] hi
    );
        logic [SIZE_BITS-1:0] r;
        begin
            if (v < MIN_SIZE) begin
                r = MIN_SIZE;
            end else if (v > hi) begin
                r = hi;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/binomial_downsample_by_two.sv]
//------------------------------------------------------------------------------
// binomial_downsample_by_two
// 3x3 binomial (1-2-1) 2:1 reduction of a raster height field.
//------------------------------------------------------------------------------
// Input: one signed Q15.8 sample per beat on s_*, raster order, frame size
// set by source_width / source_height (clamped to 3..1024) on the cfg port.
// A cfg write restarts the frame; write only while no beats are in flight.
// Output: one beat per even (x,y) position, ((W-1)/2+1) x ((H-1)/2+1) per
// frame; m_tlast marks the last beat of an output row, m_tuser the last
// beat of the frame. Edges are clamped.
// Throughput: one input beat per cycle while s_tready is high. Each beat does
// one read of the line store and one write back of the same column in the
// following cycle; the column sum, then the horizontal sum and rounding, are
// two pipeline stages. The input beat that completes a window passes through
// stage 1, stage 2 and the output buffer before its result appears on m_*.
// Stall: results queue in a 4-entry buffer; s_tready drops only in reset or
// when the buffer and the in-flight stages could fill it.
// Reset: frame position cleared, size registers back to 1024, no outputs
// pending. The line store needs no clearing.
//------------------------------------------------------------------------------
`default_nettype none

module binomial_downsample_by_two (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [bdt_pkg::SAMPLE_BITS-1:0]   s_tdata,   // [23:0] sample
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [bdt_pkg::SAMPLE_BITS-1:0]   m_tdata,   // [23:0] value
    output logic                                   m_tlast,   // end_of_row
    output logic                                   m_tuser,   // [0] end_of_frame
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [bdt_pkg::SIZE_BITS-1:0]     cfg_data
);

    localparam logic [bdt_pkg::SIZE_BITS-1:0] MAX_W =
        bdt_pkg::SIZE_BITS'(bdt_pkg::MAX_WIDTH);
    localparam logic [bdt_pkg::SIZE_BITS-1:0] MAX_H =
        bdt_pkg::SIZE_BITS'(bdt_pkg::MAX_HEIGHT);

    logic [bdt_pkg::SIZE_BITS-1:0] width_reg, height_reg;
    logic [bdt_pkg::COL_BITS-1:0]  col_reg, col_next;
    logic [bdt_pkg::ROW_BITS-1:0]  row_reg, row_next;

    logic                          accept;
    logic                          restart;
    logic                          last_col, last_row;
    bdt_pkg::pos_ctrl_t            ctrl;
    bdt_pkg::pipe_busy_t           busy;
    bdt_pkg::out_beat_t            push_beat, out_beat;
    logic                          push;
    logic [bdt_pkg::FIFO_CNT-1:0]  fifo_count;
    logic [bdt_pkg::FIFO_CNT-1:0]  pending;
    logic [bdt_pkg::WORD_BITS-1:0] rd_data, wr_data;
    logic [bdt_pkg::COL_BITS-1:0]  wr_addr;
    logic                          wr_en;

    assign restart = cfg_we;
    assign accept  = s_tvalid & s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= MAX_W;
            height_reg <= MAX_H;
        end else if (cfg_we) begin
            unique case (bdt_pkg::cfg_reg_t'(cfg_index))
                bdt_pkg::REG_SOURCE_WIDTH:
                    width_reg  <= bdt_pkg::clamp_size(cfg_data, MAX_W);
                bdt_pkg::REG_SOURCE_HEIGHT:
                    height_reg <= bdt_pkg::clamp_size(cfg_data, MAX_H);
                default: ;
            endcase
        end
    end

    assign last_col = ({1'b0, col_reg} == width_reg - 1'b1);
    assign last_row = ({1'b0, row_reg} == height_reg - 1'b1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign ctrl.col        = col_reg;
    assign ctrl.row_odd    = row_reg[0];
    assign ctrl.row_is_one = (row_reg == bdt_pkg::ROW_BITS'(1));
    assign ctrl.last_row   = last_row;
    assign ctrl.last_col   = last_col;
    assign ctrl.col_odd    = col_reg[0];
    assign ctrl.col_is_one = (col_reg == bdt_pkg::COL_BITS'(1));

    // room for everything already queued or in flight
    assign pending  = fifo_count + bdt_pkg::FIFO_CNT'(busy.s1_valid)
                    + bdt_pkg::FIFO_CNT'(busy.s2_valid);
    assign s_tready = aresetn && (pending < bdt_pkg::FIFO_CNT'(bdt_pkg::FIFO_DEPTH));

    bdt_line_store u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bdt_filter u_filter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .in_valid  (accept),
        .in_ctrl   (ctrl),
        .in_sample (s_tdata),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_beat (push_beat),
        .busy      (busy)
    );

    bdt_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_beat (push_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .count     (fifo_count)
    );

    assign m_tdata = out_beat.value;
    assign m_tlast = out_beat.end_of_row;
    assign m_tuser = out_beat.end_of_frame;

endmodule

`default_nettype wire

[hdl/bdt_line_store.sv]
//------------------------------------------------------------------------------
// bdt_line_store
// Two-row line store: each word holds {row r-1, row r-2} for one column.
//------------------------------------------------------------------------------
`default_nettype none

module bdt_line_store (
    input  wire logic                             aclk,
    input  wire logic                             rd_en,
    input  wire logic [bdt_pkg::COL_BITS-1:0]     rd_addr,
    output logic      [bdt_pkg::WORD_BITS-1:0]    rd_data,
    input  wire logic                             wr_en,
    input  wire logic [bdt_pkg::COL_BITS-1:0]     wr_addr,
    input  wire logic [bdt_pkg::WORD_BITS-1:0]    wr_data
);

    logic [bdt_pkg::WORD_BITS-1:0] mem [bdt_pkg::MAX_WIDTH];
    logic [bdt_pkg::WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/bdt_filter.sv]
//------------------------------------------------------------------------------
// bdt_filter
// Column sums from the line store, horizontal window and rounded output.
//------------------------------------------------------------------------------
`default_nettype none

module bdt_filter (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  restart,
    input  wire logic                                  in_valid,
    input  wire bdt_pkg::pos_ctrl_t                    in_ctrl,
    input  wire logic signed [bdt_pkg::SAMPLE_BITS-1:0] in_sample,
    input  wire logic [bdt_pkg::WORD_BITS-1:0]         rd_data,
    output logic                                       wr_en,
    output logic      [bdt_pkg::COL_BITS-1:0]          wr_addr,
    output logic      [bdt_pkg::WORD_BITS-1:0]         wr_data,
    output logic                                       push,
    output bdt_pkg::out_beat_t                         push_beat,
    output bdt_pkg::pipe_busy_t                        busy
);

    localparam int SB  = bdt_pkg::SAMPLE_BITS;
    localparam int CSB = bdt_pkg::COLSUM_BITS;
    localparam int TB  = bdt_pkg::TOTAL_BITS;

    // stage 1: line store data arrives
    logic                  s1_valid_reg;
    bdt_pkg::pos_ctrl_t    s1_ctrl_reg;
    logic signed [SB-1:0]  s1_sample_reg;

    logic signed [CSB-1:0] win0_reg, win1_reg;

    // stage 2: horizontal sum and rounding
    logic                  s2_valid_reg;
    logic                  s2_odd_reg;
    logic                  s2_eor_reg;
    logic                  s2_eof_reg;
    logic signed [CSB-1:0] s2_left_reg, s2_w0_reg, s2_cs_reg;

    logic signed [SB-1:0]  above, mid;
    logic signed [CSB-1:0] above_x, mid_x, s_x, colsum;
    logic                  row_emit, col_emit;
    logic signed [TB-1:0]  left_t, w0_t, cs_t, total, biased;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            s1_ctrl_reg   <= in_ctrl;
            s1_sample_reg <= in_sample;
        end
    end

    always_comb begin
        mid     = rd_data[2*SB-1:SB];
        above   = rd_data[SB-1:0];
        if (s1_ctrl_reg.row_is_one) begin
            above = mid;
        end
        above_x = {{(CSB-SB){above[SB-1]}}, above};
        mid_x   = {{(CSB-SB){mid[SB-1]}}, mid};
        s_x     = {{(CSB-SB){s1_sample_reg[SB-1]}}, s1_sample_reg};
        if (s1_ctrl_reg.row_odd) begin
            colsum   = above_x + (mid_x <<< 1) + s_x;
            row_emit = 1'b1;
        end else if (s1_ctrl_reg.last_row) begin
            colsum   = mid_x + (s_x <<< 1) + s_x;
            row_emit = 1'b1;
        end else begin
            colsum   = '0;
            row_emit = 1'b0;
        end
        col_emit = s1_ctrl_reg.col_odd | s1_ctrl_reg.last_col;
    end

    // {row r-1, row r-2} <- {new sample, old row r-1}
    assign wr_en   = s1_valid_reg;
    assign wr_addr = s1_ctrl_reg.col;
    assign wr_data = {s1_sample_reg, mid};

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            win0_reg <= '0;
            win1_reg <= '0;
        end else if (s1_valid_reg) begin
            win1_reg <= win0_reg;
            win0_reg <= colsum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg & row_emit & col_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_left_reg <= s1_ctrl_reg.col_is_one ? win0_reg : win1_reg;
            s2_w0_reg   <= win0_reg;
            s2_cs_reg   <= colsum;
            s2_odd_reg  <= s1_ctrl_reg.col_odd;
            s2_eor_reg  <= s1_ctrl_reg.last_col;
            s2_eof_reg  <= s1_ctrl_reg.last_col & s1_ctrl_reg.last_row;
        end
    end

    always_comb begin
        left_t = {{(TB-CSB){s2_left_reg[CSB-1]}}, s2_left_reg};
        w0_t   = {{(TB-CSB){s2_w0_reg[CSB-1]}}, s2_w0_reg};
        cs_t   = {{(TB-CSB){s2_cs_reg[CSB-1]}}, s2_cs_reg};
        if (s2_odd_reg) begin
            total = left_t + (w0_t <<< 1) + cs_t;
        end else begin
            total = w0_t + (cs_t <<< 1) + cs_t;
        end
        biased = total + TB'(8);
    end

    // floor((sum + 8) / 16)
    assign push                   = s2_valid_reg;
    assign push_beat.value        = biased[SB+3:4];
    assign push_beat.end_of_row   = s2_eor_reg;
    assign push_beat.end_of_frame = s2_eof_reg;

    assign busy.s1_valid = s1_valid_reg;
    assign busy.s2_valid = s2_valid_reg;

endmodule

`default_nettype wire

[hdl/bdt_out_fifo.sv]
//------------------------------------------------------------------------------
// bdt_out_fifo
// Small result queue that decouples the filter from output stalls.
//------------------------------------------------------------------------------
`default_nettype none

module bdt_out_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire bdt_pkg::out_beat_t            push_beat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bdt_pkg::out_beat_t                 out_beat,
    output logic [bdt_pkg::FIFO_CNT-1:0]       count
);

    bdt_pkg::out_beat_t                mem [bdt_pkg::FIFO_DEPTH];
    logic [bdt_pkg::FIFO_PTR-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [bdt_pkg::FIFO_CNT-1:0]      count_reg;
    logic                              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_beat  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/bdt_checker.sv]
//------------------------------------------------------------------------------
// bdt_checker
// Port-level checks for binomial_downsample_by_two.
//------------------------------------------------------------------------------
`default_nettype none

module bdt_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [bdt_pkg::SAMPLE_BITS-1:0] m_tdata,
    input wire logic                            m_tlast,
    input wire logic                            m_tuser
);

    // result beat held while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped during stall");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=>
            $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("result beat changed during stall");

    // frame end is always a row end
    a_eof_eor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of row");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat after reset");

endmodule

bind binomial_downsample_by_two bdt_checker u_bdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
